[rtl/bps_pkg.sv]
// Shared constants, types and helpers for the bilinear pixel sampler.
`default_nettype none

package bps_pkg;

    // Fixed field widths of the transaction ports
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 8;
    localparam int CHAN_W    = 2;
    localparam int COORD_W   = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Default sizing of the pixel store and the coordinate format
    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_MAX_CHANNELS  = 3;
    localparam int DEF_FRACTION_BITS = 8;

    // Image size held by the size registers after reset
    localparam int RESET_SIZE = 256;

    // Queue depths; the result queue also bounds samples in flight
    localparam int IN_QUEUE_DEPTH  = 4;
    localparam int OUT_QUEUE_DEPTH = 8;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Transaction kinds on the mode field
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Fill level flags of a queue
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Pick one of four pixel values by a two-bit select
    function automatic logic [PIX_W-1:0] pick4(
        input logic [1:0]       sel,
        input logic [PIX_W-1:0] d0,
        input logic [PIX_W-1:0] d1,
        input logic [PIX_W-1:0] d2,
        input logic [PIX_W-1:0] d3
    );
        logic [PIX_W-1:0] res;
        case (sel)
            2'd0:    res = d0;
            2'd1:    res = d1;
            2'd2:    res = d2;
            default: res = d3;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/bps_queue.sv]
// Small first-in first-out queue of fixed-width entries.
`default_nettype none

module bps_queue
    import bps_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output q_status_t             status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = store[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

[rtl/bps_front.sv]
// Front end: size registers, transaction classification and coordinate split.
`default_nettype none

module bps_front
    import bps_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int ENTRY_W       = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 mode,
    input  wire logic [ROW_W-1:0]     pixel_row,
    input  wire logic [COL_W-1:0]     pixel_column,
    input  wire logic [CHAN_W-1:0]    channel,
    input  wire logic [PIX_W-1:0]     pixel_value,
    input  wire logic [COORD_W-1:0]   sample_x,
    input  wire logic [COORD_W-1:0]   sample_y,
    input  q_status_t                 q_stat,
    output logic                      push,
    output logic      [ENTRY_W-1:0]   entry
);

    localparam int X_BITS  = $clog2(MAX_WIDTH);
    localparam int Y_BITS  = $clog2(MAX_HEIGHT);
    localparam int CHAN_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int IP_BITS = COORD_W - FRACTION_BITS;
    localparam int CXW     = (IP_BITS > X_BITS) ? IP_BITS : X_BITS;
    localparam int CYW     = (IP_BITS > Y_BITS) ? IP_BITS : Y_BITS;
    localparam int SZXW    = (CFG_W > X_BITS + 1) ? CFG_W : X_BITS + 1;
    localparam int SZYW    = (CFG_W > Y_BITS + 1) ? CFG_W : Y_BITS + 1;
    localparam int RCW     = (ROW_W > $clog2(MAX_HEIGHT + 1)) ? ROW_W : $clog2(MAX_HEIGHT + 1);
    localparam int CCW     = (COL_W > $clog2(MAX_WIDTH + 1)) ? COL_W : $clog2(MAX_WIDTH + 1);
    localparam int CHW     = (CHAN_W > $clog2(MAX_CHANNELS + 1)) ?
                             CHAN_W : $clog2(MAX_CHANNELS + 1);
    localparam int RST_LAST_X = ((MAX_WIDTH < RESET_SIZE) ? MAX_WIDTH : RESET_SIZE) - 1;
    localparam int RST_LAST_Y = ((MAX_HEIGHT < RESET_SIZE) ? MAX_HEIGHT : RESET_SIZE) - 1;

    typedef struct packed {
        logic                     is_write;
        logic                     zero;
        logic [CHAN_AW-1:0]       chan;
        logic [X_BITS-1:0]        x0;
        logic [X_BITS-1:0]        x1;
        logic [Y_BITS-1:0]        y0;
        logic [Y_BITS-1:0]        y1;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fy;
        logic [PIX_W-1:0]         value;
    } entry_t;

    // Last valid column and row index, kept instead of the raw sizes
    logic [X_BITS-1:0] last_x_reg, last_x_next;
    logic [Y_BITS-1:0] last_y_reg, last_y_next;

    logic [SZXW-1:0]          cfg_wx;
    logic [SZYW-1:0]          cfg_hy;
    logic [X_BITS-1:0]        cfg_last_x;
    logic [Y_BITS-1:0]        cfg_last_y;

    logic [CXW-1:0]           ipx_c, lastx_c;
    logic [CYW-1:0]           ipy_c, lasty_c;
    logic [X_BITS-1:0]        x0, x1;
    logic [Y_BITS-1:0]        y0, y1;
    logic [FRACTION_BITS-1:0] fx, fy;

    logic                     row_ok, col_ok, chan_ok, keep;
    entry_t                   entry_s;

    // Turn a written size into a last index: zero acts as one, large values saturate
    always_comb
    begin
        cfg_wx = SZXW'(cfg_data);
        cfg_hy = SZYW'(cfg_data);
        if (cfg_data == '0)
        begin
            cfg_last_x = '0;
        end
        else if (cfg_wx > SZXW'(MAX_WIDTH))
        begin
            cfg_last_x = X_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            cfg_last_x = X_BITS'(cfg_wx - SZXW'(1));
        end
        if (cfg_data == '0)
        begin
            cfg_last_y = '0;
        end
        else if (cfg_hy > SZYW'(MAX_HEIGHT))
        begin
            cfg_last_y = Y_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            cfg_last_y = Y_BITS'(cfg_hy - SZYW'(1));
        end
    end

    // Update size registers on a configuration write
    always_comb
    begin
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  last_x_next = cfg_last_x;
                REG_IMAGE_HEIGHT: last_y_next = cfg_last_y;
                default:          last_x_next = last_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg <= X_BITS'(RST_LAST_X);
            last_y_reg <= Y_BITS'(RST_LAST_Y);
        end
        else
        begin
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
        end
    end

    // Split column coordinate: saturate past the edge, clamp the right neighbor
    always_comb
    begin
        ipx_c   = CXW'(sample_x[COORD_W-1:FRACTION_BITS]);
        lastx_c = CXW'(last_x_reg);
        if (ipx_c >= lastx_c)
        begin
            x0 = last_x_reg;
            x1 = last_x_reg;
            fx = (ipx_c > lastx_c) ? '0 : sample_x[FRACTION_BITS-1:0];
        end
        else
        begin
            x0 = ipx_c[X_BITS-1:0];
            x1 = ipx_c[X_BITS-1:0] + X_BITS'(1);
            fx = sample_x[FRACTION_BITS-1:0];
        end
    end

    // Split row coordinate the same way
    always_comb
    begin
        ipy_c   = CYW'(sample_y[COORD_W-1:FRACTION_BITS]);
        lasty_c = CYW'(last_y_reg);
        if (ipy_c >= lasty_c)
        begin
            y0 = last_y_reg;
            y1 = last_y_reg;
            fy = (ipy_c > lasty_c) ? '0 : sample_y[FRACTION_BITS-1:0];
        end
        else
        begin
            y0 = ipy_c[Y_BITS-1:0];
            y1 = ipy_c[Y_BITS-1:0] + Y_BITS'(1);
            fy = sample_y[FRACTION_BITS-1:0];
        end
    end

    // Classify the transaction and build the queue entry
    always_comb
    begin
        row_ok  = (RCW'(pixel_row) < RCW'(MAX_HEIGHT));
        col_ok  = (CCW'(pixel_column) < CCW'(MAX_WIDTH));
        chan_ok = (CHW'(channel) < CHW'(MAX_CHANNELS));

        entry_s.chan = CHAN_AW'(channel);
        if (mode == MODE_WRITE)
        begin
            entry_s.is_write = 1'b1;
            entry_s.zero     = 1'b0;
            entry_s.x0       = X_BITS'(pixel_column);
            entry_s.x1       = X_BITS'(pixel_column);
            entry_s.y0       = Y_BITS'(pixel_row);
            entry_s.y1       = Y_BITS'(pixel_row);
            entry_s.fx       = '0;
            entry_s.fy       = '0;
            entry_s.value    = pixel_value;
            keep             = row_ok && col_ok && chan_ok;
        end
        else
        begin
            entry_s.is_write = 1'b0;
            entry_s.zero     = !chan_ok;
            entry_s.x0       = x0;
            entry_s.x1       = x1;
            entry_s.y0       = y0;
            entry_s.y1       = y1;
            entry_s.fx       = fx;
            entry_s.fy       = fy;
            entry_s.value    = '0;
            keep             = 1'b1;
        end
    end

    // Drop writes outside the store, queue everything else
    assign push  = in_valid && !q_stat.full && keep;
    assign entry = entry_s;

endmodule

`default_nettype wire

[rtl/bps_back.sv]
// Back end: banked pixel store, two-stage blend pipeline and result queue.
`default_nettype none

module bps_back
    import bps_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int ENTRY_W       = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  q_status_t               q_stat,
    input  wire logic [ENTRY_W-1:0] q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [PIX_W-1:0]   sample_value
);

    localparam int X_BITS  = $clog2(MAX_WIDTH);
    localparam int Y_BITS  = $clog2(MAX_HEIGHT);
    localparam int CHAN_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int XH      = (X_BITS > 1) ? X_BITS - 1 : 1;
    localparam int YH      = (Y_BITS > 1) ? Y_BITS - 1 : 1;
    localparam int BANK_AW = YH + XH + CHAN_AW;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int HW      = PIX_W + FRACTION_BITS;
    localparam int DW      = HW + 2;
    localparam int TW      = PIX_W + 2 * FRACTION_BITS + 2;
    localparam int CRD_W   = $clog2(OUT_QUEUE_DEPTH + 1);
    localparam logic [TW-1:0] ROUND_HALF = TW'(1) << (2 * FRACTION_BITS - 1);

    typedef struct packed {
        logic                     is_write;
        logic                     zero;
        logic [CHAN_AW-1:0]       chan;
        logic [X_BITS-1:0]        x0;
        logic [X_BITS-1:0]        x1;
        logic [Y_BITS-1:0]        y0;
        logic [Y_BITS-1:0]        y1;
        logic [FRACTION_BITS-1:0] fx;
        logic [FRACTION_BITS-1:0] fy;
        logic [PIX_W-1:0]         value;
    } entry_t;

    entry_t                   ent;
    logic                     issue_sample;
    logic                     deliver;
    logic [CRD_W-1:0]         credit_reg, credit_next;

    logic [Y_BITS-1:0]        row_even, row_odd;
    logic [X_BITS-1:0]        col_even, col_odd;
    logic [BANK_AW-1:0]       wr_addr;
    logic [BANK_AW-1:0]       rd_addr [4];
    logic [3:0]               bank_we;
    logic [PIX_W-1:0]         rd_q [4];

    // Stage 1: bank data arrives with the blend controls
    logic                     s1_valid_reg;
    logic                     s1_zero_reg;
    logic [FRACTION_BITS-1:0] s1_fx_reg, s1_fy_reg;
    logic [3:0]               s1_sel_reg;
    logic [PIX_W-1:0]         v00, v10, v01, v11;
    logic signed [DW-1:0]     fx_s, d0_s, d1_s, h0_s, h1_s;

    // Stage 2: horizontal blends
    logic                     s2_valid_reg;
    logic                     s2_zero_reg;
    logic [FRACTION_BITS-1:0] s2_fy_reg;
    logic [HW-1:0]            s2_h0_reg, s2_h1_reg;
    logic signed [TW-1:0]     e_s, fy_s, tot_s;
    logic [TW-1:0]            rnd_u, quot_u;
    logic [PIX_W-1:0]         result;

    q_status_t                oq_stat;

    assign ent = entry_t'(q_data);

    // Issue a sample only while the result queue has room for everything in flight
    assign q_pop        = !q_stat.empty &&
                          (ent.is_write || (credit_reg < CRD_W'(OUT_QUEUE_DEPTH)));
    assign issue_sample = q_pop && !ent.is_write;
    assign deliver      = out_valid && !out_stall;
    assign credit_next  = credit_reg + CRD_W'(issue_sample) - CRD_W'(deliver);

    // Route rows and columns to the banks by parity
    always_comb
    begin
        row_even = ent.y0[0] ? ent.y1 : ent.y0;
        row_odd  = ent.y0[0] ? ent.y0 : ent.y1;
        col_even = ent.x0[0] ? ent.x1 : ent.x0;
        col_odd  = ent.x0[0] ? ent.x0 : ent.x1;

        rd_addr[0] = {YH'(row_even >> 1), XH'(col_even >> 1), ent.chan};
        rd_addr[1] = {YH'(row_even >> 1), XH'(col_odd >> 1),  ent.chan};
        rd_addr[2] = {YH'(row_odd >> 1),  XH'(col_even >> 1), ent.chan};
        rd_addr[3] = {YH'(row_odd >> 1),  XH'(col_odd >> 1),  ent.chan};

        wr_addr = {YH'(ent.y0 >> 1), XH'(ent.x0 >> 1), ent.chan};
        bank_we = '0;
        if (q_pop && ent.is_write)
        begin
            bank_we[{ent.y0[0], ent.x0[0]}] = 1'b1;
        end
    end

    // Hold the four pixel banks; each reads once and writes once a cycle
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [PIX_W-1:0] mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[wr_addr] <= ent.value;
            end
            rd_q[b] <= mem[rd_addr[b]];
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s1_valid_reg <= issue_sample;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_zero_reg <= ent.zero;
        s1_fx_reg   <= ent.fx;
        s1_fy_reg   <= ent.fy;
        s1_sel_reg  <= {ent.y0[0], ent.y1[0], ent.x0[0], ent.x1[0]};
        s2_zero_reg <= s1_zero_reg;
        s2_fy_reg   <= s1_fy_reg;
        s2_h0_reg   <= h0_s[HW-1:0];
        s2_h1_reg   <= h1_s[HW-1:0];
    end

    // Select neighbors and blend along the row
    always_comb
    begin
        v00 = pick4({s1_sel_reg[3], s1_sel_reg[1]}, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
        v10 = pick4({s1_sel_reg[3], s1_sel_reg[0]}, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
        v01 = pick4({s1_sel_reg[2], s1_sel_reg[1]}, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);
        v11 = pick4({s1_sel_reg[2], s1_sel_reg[0]}, rd_q[0], rd_q[1], rd_q[2], rd_q[3]);

        fx_s = signed'(DW'(s1_fx_reg));
        d0_s = signed'(DW'(v10)) - signed'(DW'(v00));
        d1_s = signed'(DW'(v11)) - signed'(DW'(v01));
        h0_s = signed'(DW'(v00) << FRACTION_BITS) + d0_s * fx_s;
        h1_s = signed'(DW'(v01) << FRACTION_BITS) + d1_s * fx_s;
    end

    // Blend along the column, round half up and saturate, or give zero for a missing channel
    always_comb
    begin
        fy_s   = signed'(TW'(s2_fy_reg));
        e_s    = signed'(TW'(s2_h1_reg)) - signed'(TW'(s2_h0_reg));
        tot_s  = signed'(TW'(s2_h0_reg) << FRACTION_BITS) + e_s * fy_s;
        rnd_u  = unsigned'(tot_s) + ROUND_HALF;
        quot_u = rnd_u >> (2 * FRACTION_BITS);
        if (s2_zero_reg)
        begin
            result = '0;
        end
        else if (quot_u > TW'(PIX_MAX))
        begin
            result = PIX_MAX;
        end
        else
        begin
            result = quot_u[PIX_W-1:0];
        end
    end

    // Hold finished results until the receiver takes them
    bps_queue #(
        .WIDTH (PIX_W),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s2_valid_reg),
        .push_data (result),
        .pop       (deliver),
        .pop_data  (sample_value),
        .status    (oq_stat)
    );

    assign out_valid = !oq_stat.empty;

endmodule

`default_nettype wire

[rtl/bilinear_pixel_sampler.sv]
// Top level of the bilinear pixel sampler: front end, entry queue and back end.
//
// Usage:
//   Input channel (in_valid / in_stall) carries two transaction kinds. A write
//   (mode 0) stores pixel_value at pixel_row, pixel_column, channel and gives no
//   result; writes outside the store are dropped. A sample (mode 1) gives one
//   sample_value on the output channel (out_valid / out_stall), in order.
//   Configuration: cfg_write_en with cfg_index selects image width (0) or
//   height (1); write them only while no transaction is outstanding.
//   Throughput: one transaction per cycle while in_stall is low, set by the four
//   parity banks of the pixel store, which serve all four neighbor reads at once.
//   Path: an accepted sample passes the entry queue, bank read, row blend and
//   column blend into the result queue, where it shows out_valid.
//   Up to eight samples may be in flight; at that point the back end holds
//   further samples in the entry queue, and in_stall rises once it is full.
//   A stalled receiver holds the head result on sample_value unchanged.
//   Reset: queues empty, width and height return to 256 (or the store limit);
//   pixel contents stay undefined until written.
`default_nettype none

module bilinear_pixel_sampler
    import bps_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [ROW_W-1:0]     pixel_row,
    input  wire logic [COL_W-1:0]     pixel_column,
    input  wire logic [CHAN_W-1:0]    channel,
    input  wire logic [PIX_W-1:0]     pixel_value,
    input  wire logic [COORD_W-1:0]   sample_x,
    input  wire logic [COORD_W-1:0]   sample_y,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [PIX_W-1:0]     sample_value
);

    localparam int X_BITS  = $clog2(MAX_WIDTH);
    localparam int Y_BITS  = $clog2(MAX_HEIGHT);
    localparam int CHAN_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ENTRY_W = 2 + CHAN_AW + 2 * X_BITS + 2 * Y_BITS
                           + 2 * FRACTION_BITS + PIX_W;

    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] head_entry;
    q_status_t          iq_stat;

    // Stall the sender while the entry queue is full
    assign in_stall = iq_stat.full;

    bps_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .MAX_CHANNELS  (MAX_CHANNELS),
        .FRACTION_BITS (FRACTION_BITS),
        .ENTRY_W       (ENTRY_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .mode         (mode),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .channel      (channel),
        .pixel_value  (pixel_value),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .q_stat       (iq_stat),
        .push         (push),
        .entry        (push_entry)
    );

    bps_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_entry_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (head_entry),
        .status    (iq_stat)
    );

    bps_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .MAX_CHANNELS  (MAX_CHANNELS),
        .FRACTION_BITS (FRACTION_BITS),
        .ENTRY_W       (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (iq_stat),
        .q_data       (head_entry),
        .q_pop        (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value)
    );

endmodule

`default_nettype wire

[verif/bilinear_pixel_sampler_tb.sv]
// Self-checking testbench for the bilinear pixel sampler: directed and random transactions.
`timescale 1ns / 1ps

module bilinear_pixel_sampler_tb;
    import bps_pkg::*;

    localparam int unsigned STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT * DEF_MAX_CHANNELS;
    localparam int unsigned FRAC_ONE    = 1 << DEF_FRACTION_BITS;
    localparam int          RAND_ITEMS  = 90;
    localparam int          NUM_PHASES  = 12;
    localparam int          SETTLE_CYC  = 16;

    // Blend predictor and in-order store of expected sample values
    class sampler_scoreboard;
        bit [CFG_W-1:0] width_reg;
        bit [CFG_W-1:0] height_reg;
        bit [PIX_W-1:0] pixel_mem [STORE_DEPTH];
        bit [PIX_W-1:0] expected_values [$];
        int             errors;

        function new();
            width_reg  = RESET_SIZE;
            height_reg = RESET_SIZE;
            errors     = 0;
        endfunction

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = data;
            else
                height_reg = data;
        endfunction

        // Treat zero as one and saturate at the store limit
        function int unsigned clamp_size(bit [CFG_W-1:0] r, int unsigned limit);
            if (r == 0)
                return 1;
            if (r > limit)
                return limit;
            return r;
        endfunction

        function int unsigned eff_width();
            return clamp_size(width_reg, DEF_MAX_WIDTH);
        endfunction

        function int unsigned eff_height();
            return clamp_size(height_reg, DEF_MAX_HEIGHT);
        endfunction

        function int unsigned mem_addr(int unsigned r, int unsigned c, int unsigned ch);
            return (r * DEF_MAX_WIDTH + c) * DEF_MAX_CHANNELS + ch;
        endfunction

        // Saturate the integer part at the last pixel; clamp the far neighbor to the edge
        function void split_coord(bit [COORD_W-1:0] coord, int unsigned size,
                                  output int unsigned lo, output int unsigned hi,
                                  output int unsigned frac);
            int unsigned ip;
            ip   = coord >> DEF_FRACTION_BITS;
            frac = coord & (FRAC_ONE - 1);
            if (ip >= size - 1)
            begin
                lo = size - 1;
                hi = size - 1;
                if (ip > size - 1)
                    frac = 0;
            end
            else
            begin
                lo = ip;
                hi = ip + 1;
            end
        endfunction

        function void neighbors(bit [COORD_W-1:0] sx, bit [COORD_W-1:0] sy,
                                output int unsigned x0, output int unsigned x1,
                                output int unsigned fx, output int unsigned y0,
                                output int unsigned y1, output int unsigned fy);
            split_coord(sx, eff_width(), x0, x1, fx);
            split_coord(sy, eff_height(), y0, y1, fy);
        endfunction

        // Update the pixel copy on a write; queue the blended value on a sample
        function void note_input(bit m, bit [ROW_W-1:0] r, bit [COL_W-1:0] c,
                                 bit [CHAN_W-1:0] ch, bit [PIX_W-1:0] v,
                                 bit [COORD_W-1:0] sx, bit [COORD_W-1:0] sy);
            int unsigned x0, x1, fx, y0, y1, fy;
            longint unsigned v00, v10, v01, v11, blend;
            if (m == MODE_WRITE)
            begin
                if (ch < DEF_MAX_CHANNELS)
                    pixel_mem[mem_addr(r, c, ch)] = v;
                return;
            end
            if (ch >= DEF_MAX_CHANNELS)
            begin
                expected_values.push_back('0);
                return;
            end
            neighbors(sx, sy, x0, x1, fx, y0, y1, fy);
            v00 = pixel_mem[mem_addr(y0, x0, ch)];
            v10 = pixel_mem[mem_addr(y0, x1, ch)];
            v01 = pixel_mem[mem_addr(y1, x0, ch)];
            v11 = pixel_mem[mem_addr(y1, x1, ch)];
            blend = longint'(FRAC_ONE - fx) * (FRAC_ONE - fy) * v00
                  + longint'(fx) * (FRAC_ONE - fy) * v10
                  + longint'(FRAC_ONE - fx) * fy * v01
                  + longint'(fx) * fy * v11;
            blend = (blend + (64'd1 << (2 * DEF_FRACTION_BITS - 1))) >> (2 * DEF_FRACTION_BITS);
            if (blend > PIX_MAX)
                blend = PIX_MAX;
            expected_values.push_back(blend[PIX_W-1:0]);
        endfunction

        function void check_result(bit [PIX_W-1:0] actual);
            bit [PIX_W-1:0] want;
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected sample_value %0d with none outstanding", $time, actual);
                errors++;
                return;
            end
            want = expected_values.pop_front();
            if (want != actual)
            begin
                $display("%0t: sample_value expected %0d, actual %0d", $time, want, actual);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_values.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [ROW_W-1:0]     pixel_row;
    logic [COL_W-1:0]     pixel_column;
    logic [CHAN_W-1:0]    channel;
    logic [PIX_W-1:0]     pixel_value;
    logic [COORD_W-1:0]   sample_x;
    logic [COORD_W-1:0]   sample_y;
    logic                 out_valid;
    logic                 out_stall;
    logic [PIX_W-1:0]     sample_value;

    sampler_scoreboard sb = new();
    bit                pixel_written [STORE_DEPTH];
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;

    bilinear_pixel_sampler DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .channel      (channel),
        .pixel_value  (pixel_value),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_value (sample_value)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop on a hang
    initial
    begin
        #5000000;
        $display("bilinear_pixel_sampler: mismatch");
        $finish;
    end

    // Drive receiver back-pressure
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Check every accepted result
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(sample_value);

    task automatic set_idle(int m);
        send_idle_pct  = (m == 1) ? 72 : (m == 3) ? 28 : 0;
        recv_stall_pct = (m == 2) ? 72 : (m == 3) ? 28 : 0;
    endtask

    // Present one transaction and hold it until accepted; enter and leave at a falling edge
    task automatic send_item(input logic m, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [CHAN_W-1:0] ch,
                             input logic [PIX_W-1:0] v, input logic [COORD_W-1:0] sx,
                             input logic [COORD_W-1:0] sy);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        pixel_row    <= r;
        pixel_column <= c;
        channel      <= ch;
        pixel_value  <= v;
        sample_x     <= sx;
        sample_y     <= sy;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(m, r, c, ch, v, sx, sy);
        @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return PIX_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Mix in-range, edge, beyond-image and fully random coordinates
    function automatic logic [COORD_W-1:0] pick_coord(int unsigned size);
        logic [7:0] ip;
        logic [7:0] fp;
        fp = $urandom;
        case ($urandom_range(0, 3))
            0: ip = $urandom_range(0, size - 1);
            1: ip = (size > 255) ? 8'd255 : $urandom_range(size - 1, size);
            2: return $urandom;
            default:
            begin
                ip = $urandom_range(0, size - 1);
                case ($urandom_range(0, 2))
                    0:       fp = 8'h00;
                    1:       fp = 8'hFF;
                    default: fp = 8'h80;
                endcase
            end
        endcase
        return {ip, fp};
    endfunction

    task automatic write_pixel(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                               input logic [CHAN_W-1:0] ch, input logic [PIX_W-1:0] v);
        send_item(MODE_WRITE, r, c, ch, v, $urandom, $urandom);
        if (ch < DEF_MAX_CHANNELS)
            pixel_written[sb.mem_addr(r, c, ch)] = 1'b1;
    endtask

    // Fill any unwritten neighbor first so no sample reads undefined pixels
    task automatic sample_pixel(input logic [CHAN_W-1:0] ch, input logic [COORD_W-1:0] sx,
                                input logic [COORD_W-1:0] sy);
        int unsigned x0, x1, fx, y0, y1, fy, r, c;
        if (ch < DEF_MAX_CHANNELS)
        begin
            sb.neighbors(sx, sy, x0, x1, fx, y0, y1, fy);
            for (int i = 0; i < 4; i++)
            begin
                r = i[1] ? y1 : y0;
                c = i[0] ? x1 : x0;
                if (!pixel_written[sb.mem_addr(r, c, ch)])
                    write_pixel(r, c, ch, pick_value());
            end
        end
        send_item(MODE_SAMPLE, $urandom, $urandom, ch, $urandom, sx, sy);
    endtask

    // Drop valid, wait for all results, then let trailing writes settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_IMAGE_WIDTH;
        cfg_data     <= w;
        sb.set_reg(REG_IMAGE_WIDTH, w);
        @(negedge clk);
        cfg_index    <= REG_IMAGE_HEIGHT;
        cfg_data     <= h;
        sb.set_reg(REG_IMAGE_HEIGHT, h);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic run_random(int n);
        int unsigned ew, eh, pick;
        ew = sb.eff_width();
        eh = sb.eff_height();
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                sample_pixel($urandom_range(0, DEF_MAX_CHANNELS - 1), pick_coord(ew),
                             pick_coord(eh));
            else if (pick < 85)
                write_pixel($urandom_range(0, eh - 1), $urandom_range(0, ew - 1),
                            $urandom_range(0, DEF_MAX_CHANNELS - 1), pick_value());
            else if (pick < 92)
                sample_pixel(2'd3, $urandom, $urandom);
            else
                write_pixel($urandom, $urandom, $urandom_range(0, 3), $urandom);
        end
    endtask

    // Main sequence
    initial
    begin
        logic [CFG_W-1:0] w, h;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = MODE_WRITE;
        pixel_row    = '0;
        pixel_column = '0;
        channel      = '0;
        pixel_value  = '0;
        sample_x     = '0;
        sample_y     = '0;
        set_idle(0);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: checkerboard blend, exact corner, far edge, rounding at full scale
        write_pixel(0, 0, 0, 8'd0);
        write_pixel(0, 1, 0, 8'd255);
        write_pixel(1, 0, 0, 8'd255);
        write_pixel(1, 1, 0, 8'd0);
        sample_pixel(0, 16'h0080, 16'h0080);
        sample_pixel(0, 16'h0000, 16'h0000);
        sample_pixel(0, 16'h00FF, 16'h0001);
        write_pixel(254, 254, 2, 8'd255);
        write_pixel(254, 255, 2, 8'd255);
        write_pixel(255, 254, 2, 8'd255);
        write_pixel(255, 255, 2, 8'd255);
        sample_pixel(2, 16'hFFFF, 16'hFFFF);
        sample_pixel(2, 16'hFEFF, 16'hFEFF);
        sample_pixel(2, 16'hFE01, 16'hFF80);
        // Missing channel: write dropped, sample reads as zero
        write_pixel(0, 0, 3, 8'hAA);
        sample_pixel(3, 16'h1234, 16'h5678);
        sample_pixel(0, 16'h0000, 16'h0000);
        sample_pixel(1, 16'h7F80, 16'h8001);
        sample_pixel(1, 16'h8001, 16'h7F80);

        // Random phases over a spread of image sizes and idling patterns
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    w = RESET_SIZE;
                    h = RESET_SIZE;
                end
                1:
                begin
                    w = 9'd0;
                    h = 9'd0;
                end
                2:
                begin
                    w = 9'd1;
                    h = 9'd2;
                end
                3:
                begin
                    w = 9'd2;
                    h = 9'd1;
                end
                4:
                begin
                    w = 9'd3;
                    h = 9'd4;
                end
                5:
                begin
                    w = 9'd511;
                    h = 9'd300;
                end
                6:
                begin
                    w = 9'd256;
                    h = 9'd256;
                end
                7:
                begin
                    w = 9'd257;
                    h = 9'd5;
                end
                8:
                begin
                    w = 9'd7;
                    h = 9'd256;
                end
                9, 10:
                begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 16);
                end
                default:
                begin
                    w = $urandom;
                    h = $urandom;
                end
            endcase
            if (phase != 0)
                set_size(w, h);
            set_idle(phase % 4);
            run_random(RAND_ITEMS);
        end

        // Wait out the tail and report
        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bilinear_pixel_sampler: match");
        else
            $display("bilinear_pixel_sampler: mismatch");
        $finish;
    end

endmodule

[bilinear_pixel_sampler.f]
rtl/bps_pkg.sv
rtl/bps_queue.sv
rtl/bps_front.sv
rtl/bps_back.sv
rtl/bilinear_pixel_sampler.sv
verif/bilinear_pixel_sampler_tb.sv
